// ===== sv/block_mean_adaptive_threshold_defines.svh =====
// ----------------------------------------------------------------------------
// Block mean adaptive threshold: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MEAN_ADAPTIVE_THRESHOLD_DEFINES_SVH
`define BLOCK_MEAN_ADAPTIVE_THRESHOLD_DEFINES_SVH

// A condition in one cycle forces another condition in the same cycle.
`define BMAT_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("bmat implication check failed");

// A condition in one cycle forces another condition in the next cycle.
`define BMAT_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("bmat next-cycle check failed");

// A stalled word keeps its payload.
`define BMAT_ASSERT_HOLD(lbl, vld, rdy, data) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld) && !(rdy) |=> $stable(data)) \
    else $error("bmat stalled payload changed");

`endif

// ===== sv/bmat_pkg.sv =====
// ----------------------------------------------------------------------------
// Block mean adaptive threshold package
// Word types, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package bmat_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;
  localparam int SUM_W     = 28;
  localparam int MEAN_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 4'd3;

  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;

  localparam logic CMD_STATS     = 1'b0;
  localparam logic CMD_THRESHOLD = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [7:0] binary_pixel;
    logic [7:0] local_threshold;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quot;
  } div_stat_t;

endpackage

// ===== sv/block_mean_adaptive_threshold.sv =====
// ----------------------------------------------------------------------------
// Block mean adaptive threshold
// Two-pass local block-mean binarizer over a raster pixel stream.
// ----------------------------------------------------------------------------
// A frame is sent twice in raster order. Words with cmd 0 add their pixel to
// the sum of its block; words with cmd 1 produce one output word each, whose
// threshold is the floor mean of the stored block means of the clipped 3x3
// block neighbourhood. One word is in work at a time. A cmd 0 word goes
// through a read-modify-write of the block sum memory. A cmd 1 word reads
// its n (1 to 9) neighbourhood blocks one per cycle from the block mean
// memory, followed by a division. The last cmd 0 word of a block row also
// works out one block mean per block column, one division each. After reset
// and after every register write the block works out the block grid before
// it takes the next word. A finished output word waits in an output
// register, so the next word is taken while it waits.
// ----------------------------------------------------------------------------
module block_mean_adaptive_threshold #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 1024,
  parameter int MAX_BLOCK_COLS = 64,
  parameter int MAX_BLOCK_ROWS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bmat_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bmat_pkg::out_word_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bmat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bmat_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int XSW    = $clog2(MAX_WIDTH + 1);
  localparam int YSW    = $clog2(MAX_HEIGHT + 1);
  localparam int XCW    = $clog2(MAX_WIDTH);
  localparam int YCW    = $clog2(MAX_HEIGHT);
  localparam int BCW    = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
  localparam int BRW    = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;
  localparam int BCNW   = $clog2(MAX_BLOCK_COLS + 1);
  localparam int BRNW   = $clog2(MAX_BLOCK_ROWS + 1);
  localparam int AREA_W = XSW + YSW;
  localparam int MDEPTH = MAX_BLOCK_ROWS * MAX_BLOCK_COLS;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int CW     = bmat_pkg::CFG_W;
  localparam int SUMW   = bmat_pkg::SUM_W;
  localparam int MW     = bmat_pkg::MEAN_W;

  localparam logic [3:0] S_GINIT   = 4'd0;
  localparam logic [3:0] S_GEOM    = 4'd1;
  localparam logic [3:0] S_IDLE    = 4'd2;
  localparam logic [3:0] S_ACC_RD  = 4'd3;
  localparam logic [3:0] S_ACC_WR  = 4'd4;
  localparam logic [3:0] S_MN_RD   = 4'd5;
  localparam logic [3:0] S_MN_AR   = 4'd6;
  localparam logic [3:0] S_MN_GO   = 4'd7;
  localparam logic [3:0] S_MN_DIV  = 4'd8;
  localparam logic [3:0] S_TH_RD   = 4'd9;
  localparam logic [3:0] S_TH_LAST = 4'd10;
  localparam logic [3:0] S_TH_GO   = 4'd11;
  localparam logic [3:0] S_TH_DIV  = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;
  localparam logic [3:0] S_FIN     = 4'd14;

  // Configuration registers, raw as written.
  logic [CW-1:0] img_w_q, img_h_q, blk_w_q, blk_h_q;

  // Block grid, worked out after every register write.
  logic [XSW-1:0]  size_x_q, rem_x_q, last_x_q;
  logic [YSW-1:0]  size_y_q, rem_y_q, last_y_q;
  logic [CW-1:0]   blk_x_q, blk_y_q;
  logic [BCNW-1:0] gcnt_x_q, cnt_x_q;
  logic [BRNW-1:0] gcnt_y_q, cnt_y_q;
  logic            gdone_x_q, gdone_y_q;

  // Raster position.
  logic [XCW-1:0] pcol_q, cib_q;
  logic [YCW-1:0] prow_q, rib_q;
  logic [BCW-1:0] bcol_q;
  logic [BRW-1:0] brow_q;

  logic [3:0]           state_q, state_d;
  bmat_pkg::in_word_t   word_q;
  logic                 vld_q [MAX_BLOCK_COLS];

  // Block sum memory.
  logic [SUMW-1:0] sums_mem [MAX_BLOCK_COLS];
  logic [SUMW-1:0] sums_rd_q;
  logic            sums_rd_vld_q;
  logic            sums_re, sums_we;
  logic [BCW-1:0]  sums_ra;
  logic [SUMW-1:0] sums_wd;

  // Block mean memory.
  logic [MW-1:0]  means_mem [MDEPTH];
  logic [MW-1:0]  means_rd_q;
  logic           means_rd_v_q;
  logic           means_re, means_we;
  logic [MAW-1:0] means_ra, means_wa;

  // Mean sweep and neighbourhood walk.
  logic [BCW-1:0]    mc_q, c0_q, c1_q, cc_q;
  logic [BRW-1:0]    r0_q, r1_q, rr_q;
  logic [3:0]        n_q;
  logic [11:0]       tsum_q;
  logic [SUMW-1:0]   num_q;
  logic [AREA_W-1:0] area_q;
  logic [MW-1:0]     thr_q;

  // Divider hookup.
  logic                div_start;
  logic [SUMW-1:0]     div_num;
  logic [AREA_W-1:0]   div_den;
  bmat_pkg::div_stat_t div_stat;

  logic                out_valid_q;
  bmat_pkg::out_word_t out_q;

  logic            last_col, last_row, row_block_end, blk_end;
  logic [XSW-1:0]  size_x_eff, ext_x;
  logic [YSW-1:0]  size_y_eff, ext_y;
  logic [CW-1:0]   blk_x_eff, blk_y_eff;
  logic            cfg_hit;
  logic [BCW-1:0]  nb_c0, nb_c1;
  logic [BRW-1:0]  nb_r0, nb_r1;
  logic [1:0]      nc, nr;

  // A size of zero counts as one, and a size beyond the maximum as the maximum.
  always_comb begin
    if (img_w_q == '0) begin
      size_x_eff = XSW'(1);
    end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
      size_x_eff = XSW'(MAX_WIDTH);
    end else begin
      size_x_eff = XSW'(img_w_q);
    end
    if (img_h_q == '0) begin
      size_y_eff = YSW'(1);
    end else if (32'(img_h_q) > 32'(MAX_HEIGHT)) begin
      size_y_eff = YSW'(MAX_HEIGHT);
    end else begin
      size_y_eff = YSW'(img_h_q);
    end
    blk_x_eff = (blk_w_q == '0) ? CW'(1) : blk_w_q;
    blk_y_eff = (blk_h_q == '0) ? CW'(1) : blk_h_q;
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i == bmat_pkg::REG_IMAGE_WIDTH ||
                                cfg_idx_i == bmat_pkg::REG_IMAGE_HEIGHT ||
                                cfg_idx_i == bmat_pkg::REG_BLOCK_WIDTH ||
                                cfg_idx_i == bmat_pkg::REG_BLOCK_HEIGHT);

  assign last_col = 32'(pcol_q) + 32'd1 >= 32'(size_x_q);
  assign last_row = 32'(prow_q) + 32'd1 >= 32'(size_y_q);
  assign row_block_end = (32'(brow_q) + 32'd1 < 32'(cnt_y_q)) ?
                         (32'(rib_q) + 32'd1 >= 32'(blk_y_q)) : last_row;
  assign blk_end = last_col && row_block_end;

  // Only interior blocks have the nominal extent; the last one takes the rest.
  assign ext_x = (32'(mc_q) + 32'd1 < 32'(cnt_x_q)) ? XSW'(blk_x_q) : last_x_q;
  assign ext_y = (32'(brow_q) + 32'd1 < 32'(cnt_y_q)) ? YSW'(blk_y_q) : last_y_q;

  // Neighbourhood of the current block, clipped to the grid.
  assign nb_c0 = (bcol_q != '0) ? bcol_q - BCW'(1) : '0;
  assign nb_r0 = (brow_q != '0) ? brow_q - BRW'(1) : '0;
  assign nb_c1 = (32'(bcol_q) + 32'd1 < 32'(cnt_x_q)) ? bcol_q + BCW'(1) :
                 BCW'(cnt_x_q - BCNW'(1));
  assign nb_r1 = (32'(brow_q) + 32'd1 < 32'(cnt_y_q)) ? brow_q + BRW'(1) :
                 BRW'(cnt_y_q - BRNW'(1));
  assign nc = 2'(nb_c1 - nb_c0) + 2'd1;
  assign nr = 2'(nb_r1 - nb_r0) + 2'd1;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_GINIT: state_d = S_GEOM;
      S_GEOM: begin
        if (gdone_x_q && gdone_y_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.cmd == bmat_pkg::CMD_STATS) ? S_ACC_RD : S_TH_RD;
        end
      end
      S_ACC_RD: state_d = S_ACC_WR;
      S_ACC_WR: state_d = blk_end ? S_MN_RD : S_FIN;
      S_MN_RD:  state_d = S_MN_AR;
      S_MN_AR:  state_d = S_MN_GO;
      S_MN_GO:  state_d = S_MN_DIV;
      S_MN_DIV: begin
        if (div_stat.done) begin
          state_d = (32'(mc_q) + 32'd1 >= 32'(cnt_x_q)) ? S_FIN : S_MN_RD;
        end
      end
      S_TH_RD: begin
        if (cc_q == c1_q && rr_q == r1_q) begin
          state_d = S_TH_LAST;
        end
      end
      S_TH_LAST: state_d = S_TH_GO;
      S_TH_GO:   state_d = S_TH_DIV;
      S_TH_DIV: begin
        if (div_stat.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_FIN;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_GINIT;
    endcase
    // A register write restarts the frame from any state.
    if (cfg_hit) begin
      state_d = S_GINIT;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_GINIT;
      img_w_q     <= CW'(1024);
      img_h_q     <= CW'(1024);
      blk_w_q     <= CW'(32);
      blk_h_q     <= CW'(32);
      pcol_q      <= '0;
      prow_q      <= '0;
      cib_q       <= '0;
      rib_q       <= '0;
      bcol_q      <= '0;
      brow_q      <= '0;
      gdone_x_q   <= 1'b0;
      gdone_y_q   <= 1'b0;
      cnt_x_q     <= BCNW'(1);
      cnt_y_q     <= BRNW'(1);
      out_valid_q <= 1'b0;
      means_rd_v_q <= 1'b0;
      for (int i = 0; i < MAX_BLOCK_COLS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      state_q      <= state_d;
      means_rd_v_q <= means_re;

      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (state_q == S_GINIT) begin
        gdone_x_q <= 1'b0;
        gdone_y_q <= 1'b0;
      end
      if (state_q == S_GEOM) begin
        if (!gdone_x_q && !(32'(blk_x_q) <= 32'(rem_x_q) &&
                            32'(gcnt_x_q) < 32'(MAX_BLOCK_COLS))) begin
          gdone_x_q <= 1'b1;
        end
        if (!gdone_y_q && !(32'(blk_y_q) <= 32'(rem_y_q) &&
                            32'(gcnt_y_q) < 32'(MAX_BLOCK_ROWS))) begin
          gdone_y_q <= 1'b1;
        end
        if (gdone_x_q && gdone_y_q) begin
          cnt_x_q <= (gcnt_x_q == '0) ? BCNW'(1) : gcnt_x_q;
          cnt_y_q <= (gcnt_y_q == '0) ? BRNW'(1) : gcnt_y_q;
        end
      end

      // A register write restarts the frame instead of advancing it.
      if (cfg_hit) begin
        case (cfg_idx_i)
          bmat_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i;
          bmat_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
          bmat_pkg::REG_BLOCK_WIDTH:  blk_w_q <= cfg_data_i;
          bmat_pkg::REG_BLOCK_HEIGHT: blk_h_q <= cfg_data_i;
          default: ;
        endcase
        pcol_q <= '0;
        prow_q <= '0;
        cib_q  <= '0;
        rib_q  <= '0;
        bcol_q <= '0;
        brow_q <= '0;
        for (int i = 0; i < MAX_BLOCK_COLS; i++) begin
          vld_q[i] <= 1'b0;
        end
      end else begin
        if (state_q == S_ACC_WR) begin
          vld_q[bcol_q] <= 1'b1;
        end

        if (state_q == S_FIN) begin
          if (blk_end) begin
            for (int i = 0; i < MAX_BLOCK_COLS; i++) begin
              vld_q[i] <= 1'b0;
            end
          end
          if (!last_col) begin
            pcol_q <= pcol_q + XCW'(1);
            if (32'(bcol_q) + 32'd1 < 32'(cnt_x_q) &&
                32'(cib_q) + 32'd1 >= 32'(blk_x_q)) begin
              bcol_q <= bcol_q + BCW'(1);
              cib_q  <= '0;
            end else begin
              cib_q <= cib_q + XCW'(1);
            end
          end else begin
            pcol_q <= '0;
            bcol_q <= '0;
            cib_q  <= '0;
            if (!last_row) begin
              prow_q <= prow_q + YCW'(1);
              if (32'(brow_q) + 32'd1 < 32'(cnt_y_q) &&
                  32'(rib_q) + 32'd1 >= 32'(blk_y_q)) begin
                brow_q <= brow_q + BRW'(1);
                rib_q  <= '0;
              end else begin
                rib_q <= rib_q + YCW'(1);
              end
            end else begin
              prow_q <= '0;
              brow_q <= '0;
              rib_q  <= '0;
            end
          end
        end
      end
    end
  end

  // Datapath registers; these need no reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_GINIT: begin
        size_x_q <= size_x_eff;
        size_y_q <= size_y_eff;
        rem_x_q  <= size_x_eff;
        rem_y_q  <= size_y_eff;
        blk_x_q  <= blk_x_eff;
        blk_y_q  <= blk_y_eff;
        gcnt_x_q <= '0;
        gcnt_y_q <= '0;
      end
      S_GEOM: begin
        // Count whole blocks by repeated subtraction, capped at the grid size.
        if (!gdone_x_q && 32'(blk_x_q) <= 32'(rem_x_q) &&
            32'(gcnt_x_q) < 32'(MAX_BLOCK_COLS)) begin
          rem_x_q  <= rem_x_q - XSW'(blk_x_q);
          gcnt_x_q <= gcnt_x_q + BCNW'(1);
        end
        if (!gdone_y_q && 32'(blk_y_q) <= 32'(rem_y_q) &&
            32'(gcnt_y_q) < 32'(MAX_BLOCK_ROWS)) begin
          rem_y_q  <= rem_y_q - YSW'(blk_y_q);
          gcnt_y_q <= gcnt_y_q + BRNW'(1);
        end
        // The last block spans the remainder plus one nominal block, or just the remainder when no whole block fits.
        last_x_q <= (gcnt_x_q == '0) ? rem_x_q : rem_x_q + XSW'(blk_x_q);
        last_y_q <= (gcnt_y_q == '0) ? rem_y_q : rem_y_q + YSW'(blk_y_q);
      end
      S_IDLE: begin
        word_q <= in_data_i;
        c0_q   <= nb_c0;
        c1_q   <= nb_c1;
        r0_q   <= nb_r0;
        r1_q   <= nb_r1;
        cc_q   <= nb_c0;
        rr_q   <= nb_r0;
        n_q    <= 4'(nc) * 4'(nr);
        tsum_q <= '0;
        mc_q   <= '0;
      end
      S_TH_RD: begin
        if (cc_q == c1_q) begin
          cc_q <= c0_q;
          rr_q <= rr_q + BRW'(1);
        end else begin
          cc_q <= cc_q + BCW'(1);
        end
      end
      S_MN_AR: begin
        num_q  <= sums_rd_vld_q ? sums_rd_q : '0;
        area_q <= AREA_W'(ext_x) * AREA_W'(ext_y);
      end
      S_MN_DIV: begin
        if (div_stat.done) begin
          mc_q <= mc_q + BCW'(1);
        end
      end
      S_TH_DIV: begin
        if (div_stat.done) begin
          thr_q <= div_stat.quot;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.binary_pixel    <= (word_q.pixel > thr_q) ? bmat_pkg::PIX_BLACK :
                                                            bmat_pkg::PIX_WHITE;
          out_q.local_threshold <= thr_q;
          out_q.frame_end       <= last_col && last_row;
        end
      end
      default: ;
    endcase
    if (means_rd_v_q) begin
      tsum_q <= tsum_q + 12'(means_rd_q);
    end
  end

  // Block sum memory: read in the cycle before the write back.
  assign sums_re = (state_q == S_ACC_RD) || (state_q == S_MN_RD);
  assign sums_ra = (state_q == S_MN_RD) ? mc_q : bcol_q;
  assign sums_we = (state_q == S_ACC_WR);
  assign sums_wd = (sums_rd_vld_q ? sums_rd_q : '0) + SUMW'(word_q.pixel);

  always_ff @(posedge clk_i) begin
    if (sums_we) begin
      sums_mem[bcol_q] <= sums_wd;
    end
    if (sums_re) begin
      sums_rd_q     <= sums_mem[sums_ra];
      sums_rd_vld_q <= vld_q[sums_ra];
    end
  end

  // Block mean memory.
  assign means_re = (state_q == S_TH_RD);
  assign means_ra = MAW'(32'(rr_q) * MAX_BLOCK_COLS + 32'(cc_q));
  assign means_we = (state_q == S_MN_DIV) && div_stat.done &&
                    (word_q.cmd == bmat_pkg::CMD_STATS);
  assign means_wa = MAW'(32'(brow_q) * MAX_BLOCK_COLS + 32'(mc_q));

  always_ff @(posedge clk_i) begin
    if (means_we) begin
      means_mem[means_wa] <= div_stat.quot;
    end
    if (means_re) begin
      means_rd_q <= means_mem[means_ra];
    end
  end

  // One divider serves both the block means and the neighbourhood average.
  assign div_start = (state_q == S_MN_GO) || (state_q == S_TH_GO);
  assign div_num   = (state_q == S_TH_GO) ? SUMW'(tsum_q) : num_q;
  assign div_den   = (state_q == S_TH_GO) ? AREA_W'(n_q) : area_q;

  bmat_div #(
    .DEN_W(AREA_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/bmat_div.sv =====
// ----------------------------------------------------------------------------
// Block mean adaptive threshold: quotient unit
// Restoring division with an 8-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmat_div #(
  parameter int DEN_W = 22
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bmat_pkg::SUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]           den_i,
  output bmat_pkg::div_stat_t        stat_o
);

  localparam int SW = (DEN_W + 8 > bmat_pkg::SUM_W) ? DEN_W + 8 : bmat_pkg::SUM_W;

  logic                       busy_q;
  logic [2:0]                 cnt_q;
  logic                       done_q;
  logic [SW-1:0]              rem_q;
  logic [SW-1:0]              dsh_q;
  logic [bmat_pkg::MEAN_W-1:0] quot_q;
  logic                       fits;

  // The caller guarantees that the quotient stays below 256.
  assign fits = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 3'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd7;
      end else if (busy_q) begin
        if (cnt_q == 3'd0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= SW'(num_i);
      dsh_q  <= SW'(den_i) << 7;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[bmat_pkg::MEAN_W-2:0], fits};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = quot_q;

endmodule

// ===== sv/bmat_checker.sv =====
// ----------------------------------------------------------------------------
// Block mean adaptive threshold: port checker
// Checks over time on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_mean_adaptive_threshold_defines.svh"

module bmat_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bmat_pkg::out_word_t out_data_o
);

  logic out_black, out_white, thr_full;

  assign out_black = out_data_o.binary_pixel == bmat_pkg::PIX_BLACK;
  assign out_white = out_data_o.binary_pixel == bmat_pkg::PIX_WHITE;
  assign thr_full  = out_data_o.local_threshold == bmat_pkg::PIX_WHITE;

  // An output word is never withdrawn before it is taken.
  `BMAT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `BMAT_ASSERT_HOLD(a_out_stable, out_valid_o, out_ready_i, out_data_o)
  // Only the two binary levels leave the block.
  `BMAT_ASSERT_IMPLY(a_bin_levels, out_valid_o, out_black || out_white)
  // A black pixel was above its threshold, so that threshold is below full scale.
  `BMAT_ASSERT_IMPLY(a_black_thr, out_valid_o && out_black, !thr_full)
  // A word is worked on alone: no second word is taken right after the first.
  `BMAT_ASSERT_NEXT(a_one_word, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind block_mean_adaptive_threshold bmat_checker u_bmat_checker (.*);
